// ===== hdl/sit_pkg.sv =====
`default_nettype none
package sit_pkg;

  localparam int TableDepth = 256;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeLookup = 2'd1;
  localparam logic [1:0] ModeNext = 2'd2;
  localparam logic [1:0] ModePrev = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] line;
    logic [11:0] pos;
    logic [15:0] stop_line;
    logic [11:0] stop_pos;
    logic signed [15:0] seq;
    logic        point_invalid;
    logic        prior_valid;
    logic [15:0] prior_line;
    logic [11:0] prior_pos;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        prior_kept;
    logic [7:0]  index;
    logic [15:0] hit_start_line;
    logic [11:0] hit_start_pos;
    logic [15:0] hit_end_line;
    logic [11:0] hit_end_pos;
    logic signed [15:0] hit_seq;
    logic        full_res;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_SHIFT_RD, ST_SHIFT_WR, ST_INS_WR,
    ST_LK_RD, ST_LK_PRB, ST_LK_CMP, ST_SC_RD, ST_SC_CMP, ST_EMIT_RD, ST_EMIT,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request
    logic ptr_zero;   // pointer := 0
    logic ptr_inc;    // pointer += 1
    logic ptr_dec;    // pointer -= 1
    logic ptr_count;  // pointer := entry count
    logic rd;         // read memory at pointer (or pointer-1 for shift)
    logic rd_prev;
    logic rd_probe;   // read memory at the lookup probe
    logic wr_shift;   // write read data at pointer
    logic wr_new;     // write new entry at pointer, bump count
    logic lk_init;    // set up binary search
    logic lk_step;    // evaluate probe
    logic sc_step;    // evaluate scan entry
    logic sc_init;
    logic rd_best;    // read best index
    logic emit_full;
    logic emit_none;
    logic emit_entry; // emit stored entry from read data
    logic emit_prior;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_at_end;   // pointer == count
    logic ge;           // read start >= point
    logic ptr_gt_at;    // shift pointer above insert position
    logic lk_hit;
    logic lk_stop;      // search finished without hit
    logic sc_have;
    logic sc_prior;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/sit_ctrl.sv =====
`default_nettype none
module sit_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    mode,
  input  wire logic          point_invalid,
  input  wire sit_pkg::sts_t sts,
  output logic               busy,
  output sit_pkg::cmd_t      cmd
);

  sit_pkg::state_t state, state_next;
  logic [1:0] op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sit_pkg::ST_IDLE;
      op <= sit_pkg::ModeInsert;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    busy = 1'b1;
    case (state)
      sit_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          cmd.ptr_zero = 1'b1;
          op_next = mode;
          case (mode)
            sit_pkg::ModeInsert: state_next = sit_pkg::ST_INS_RD;
            sit_pkg::ModeLookup: state_next = sit_pkg::ST_LK_RD;
            default: state_next = sit_pkg::ST_SC_RD;
          endcase
          if (mode == sit_pkg::ModeLookup && point_invalid) begin
            cmd.emit_none = 1'b1;
            state_next = sit_pkg::ST_DONE;
          end
        end
      end
      sit_pkg::ST_INS_RD: begin
        if (sts.full) begin
          cmd.emit_full = 1'b1;
          state_next = sit_pkg::ST_DONE;
        end else if (sts.ptr_at_end) begin
          cmd.ptr_count = 1'b1;
          state_next = sit_pkg::ST_SHIFT_RD;
        end else begin
          cmd.rd = 1'b1;
          state_next = sit_pkg::ST_INS_CMP;
        end
      end
      sit_pkg::ST_INS_CMP: begin
        if (sts.ge) begin
          cmd.ptr_count = 1'b1;
          state_next = sit_pkg::ST_SHIFT_RD;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next = sit_pkg::ST_INS_RD;
        end
      end
      sit_pkg::ST_SHIFT_RD: begin
        if (sts.ptr_gt_at) begin
          cmd.rd = 1'b1;
          cmd.rd_prev = 1'b1;
          state_next = sit_pkg::ST_SHIFT_WR;
        end else begin
          state_next = sit_pkg::ST_INS_WR;
        end
      end
      sit_pkg::ST_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_next = sit_pkg::ST_SHIFT_RD;
      end
      sit_pkg::ST_INS_WR: begin
        cmd.wr_new = 1'b1;
        state_next = sit_pkg::ST_EMIT_RD;
      end
      sit_pkg::ST_LK_RD: begin
        if (sts.empty) begin
          cmd.emit_none = 1'b1;
          state_next = sit_pkg::ST_DONE;
        end else begin
          cmd.lk_init = 1'b1;
          state_next = sit_pkg::ST_LK_PRB;
        end
      end
      sit_pkg::ST_LK_PRB: begin
        cmd.rd_probe = 1'b1;
        state_next = sit_pkg::ST_LK_CMP;
      end
      sit_pkg::ST_LK_CMP: begin
        cmd.lk_step = 1'b1;
        if (sts.lk_hit) begin
          cmd.emit_entry = 1'b1;
          state_next = sit_pkg::ST_DONE;
        end else if (sts.lk_stop) begin
          cmd.emit_none = 1'b1;
          state_next = sit_pkg::ST_DONE;
        end else begin
          state_next = sit_pkg::ST_LK_PRB;
        end
      end
      sit_pkg::ST_SC_RD: begin
        if (sts.ptr_at_end) begin
          state_next = sit_pkg::ST_EMIT_RD;
          cmd.rd_best = 1'b1;
        end else begin
          cmd.rd = 1'b1;
          state_next = sit_pkg::ST_SC_CMP;
        end
      end
      sit_pkg::ST_SC_CMP: begin
        cmd.sc_step = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next = sit_pkg::ST_SC_RD;
      end
      sit_pkg::ST_EMIT_RD: begin
        state_next = sit_pkg::ST_EMIT;
      end
      sit_pkg::ST_EMIT: begin
        if (op == sit_pkg::ModeInsert) cmd.emit_entry = 1'b1;
        else if (!sts.sc_have) cmd.emit_none = 1'b1;
        else if (sts.sc_prior) cmd.emit_prior = 1'b1;
        else cmd.emit_entry = 1'b1;
        state_next = sit_pkg::ST_DONE;
      end
      sit_pkg::ST_DONE: begin
        state_next = sit_pkg::ST_IDLE;
      end
      default: state_next = sit_pkg::ST_IDLE;
    endcase
    cmd.sc_init = cmd.load;
  end

endmodule
`default_nettype wire

// ===== hdl/sit_dp.sv =====
`default_nettype none
module sit_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sit_pkg::req_t req_in,
  input  wire sit_pkg::cmd_t cmd,
  output sit_pkg::sts_t      sts,
  output logic               result_valid,
  output sit_pkg::res_t      result
);

  localparam int AW = sit_pkg::AddrW;
  localparam int CW = sit_pkg::CountW;

  logic [27:0] start_mem [sit_pkg::TableDepth];
  logic [27:0] end_mem   [sit_pkg::TableDepth];
  logic [15:0] seq_mem   [sit_pkg::TableDepth];

  sit_pkg::req_t req;
  logic [CW-1:0] count, ptr, at, lo, hi;
  logic [AW-1:0] probe, best_idx, rd_addr;
  logic [27:0] rd_start, rd_end, best_key;
  logic [15:0] rd_seq;
  logic have, is_prior, lk_done;
  logic [27:0] pt;
  logic        res_v;
  sit_pkg::res_t res;

  assign pt = {req.line, req.pos};

  // Read address mux: shift reads one below pointer, lookup reads probe.
  always_comb begin
    rd_addr = ptr[AW-1:0];
    if (cmd.rd_prev) rd_addr = AW'(ptr - CW'(1));
    else if (cmd.rd_best) rd_addr = best_idx;
    else if (cmd.rd_probe) rd_addr = probe;
  end

  logic do_rd;
  assign do_rd = cmd.rd | cmd.rd_best | cmd.wr_new | cmd.rd_probe;

  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      start_mem[ptr[AW-1:0]] <= rd_start;
      end_mem[ptr[AW-1:0]] <= rd_end;
      seq_mem[ptr[AW-1:0]] <= rd_seq;
    end else if (cmd.wr_new) begin
      start_mem[ptr[AW-1:0]] <= pt;
      end_mem[ptr[AW-1:0]] <= {req.stop_line, req.stop_pos};
      seq_mem[ptr[AW-1:0]] <= req.seq;
    end
    if (do_rd && !cmd.wr_new) begin
      rd_start <= start_mem[rd_addr];
      rd_end <= end_mem[rd_addr];
      rd_seq <= seq_mem[rd_addr];
    end else if (cmd.wr_new) begin
      rd_start <= pt;
      rd_end <= {req.stop_line, req.stop_pos};
      rd_seq <= req.seq;
    end
  end

  // Lookup evaluation on the registered probe data.
  logic lt_start, ge_end;
  logic [CW-1:0] lo_n, hi_n, probe_w, sum_mid;
  logic [CW:0] mid_sum;
  assign lt_start = pt < rd_start;
  assign ge_end = !(rd_end <= pt);
  assign probe_w = {{(CW-AW){1'b0}}, probe};
  always_comb begin
    lo_n = lo;
    hi_n = hi;
    lk_done = 1'b0;
    if (lt_start) begin
      if (probe == '0) lk_done = 1'b1;
      hi_n = probe_w - CW'(1);
    end else if (!ge_end) begin
      lo_n = probe_w + CW'(1);
    end
    mid_sum = ({1'b0, lo_n} + {1'b0, hi_n}) >> 1;
    sum_mid = mid_sum[CW-1:0];
    if (!lk_done && lo_n > hi_n) lk_done = 1'b1;
    if (hi_n == {CW{1'b1}}) lk_done = 1'b1;
  end

  // Scan evaluation.
  logic sc_sel;
  always_comb begin
    if (req.mode == sit_pkg::ModeNext)
      sc_sel = rd_start > pt && (!have || best_key > rd_start);
    else
      sc_sel = rd_end <= pt && (!have || best_key < rd_end);
    if (rd_seq[15]) sc_sel = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      probe <= '0;
      res_v <= 1'b0;
    end else begin
      res_v <= cmd.emit_full | cmd.emit_none | cmd.emit_entry | cmd.emit_prior;
      if (cmd.wr_new) count <= count + CW'(1);
      if (cmd.lk_init) begin
        if ({{(CW-AW){1'b0}}, probe} >= count) probe <= '0;
      end
      if (cmd.lk_step) begin
        if (!(!lt_start && ge_end) && !(lt_start && probe == '0))
          probe <= sum_mid[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req <= req_in;
    if (cmd.ptr_zero) ptr <= '0;
    else if (cmd.ptr_count) ptr <= count;
    else if (cmd.ptr_inc) ptr <= ptr + CW'(1);
    else if (cmd.ptr_dec) ptr <= ptr - CW'(1);
    if (cmd.ptr_count) at <= ptr;
    if (cmd.lk_init) begin
      lo <= '0;
      hi <= count - CW'(1);
    end else if (cmd.lk_step) begin
      lo <= lo_n;
      hi <= hi_n;
    end
    if (cmd.sc_init) begin
      have <= req_in.prior_valid;
      is_prior <= req_in.prior_valid;
      best_key <= {req_in.prior_line, req_in.prior_pos};
      best_idx <= '0;
    end else if (cmd.sc_step && sc_sel) begin
      have <= 1'b1;
      is_prior <= 1'b0;
      best_key <= (req.mode == sit_pkg::ModeNext) ? rd_start : rd_end;
      best_idx <= ptr[AW-1:0];
    end
    res <= '0;
    if (cmd.emit_full) res.full_res <= 1'b1;
    if (cmd.emit_entry) begin
      res.found <= 1'b1;
      res.index <= 8'(cmd.lk_step ? probe_w : {{(CW-AW){1'b0}},
                      (req.mode == sit_pkg::ModeInsert) ? ptr[AW-1:0] : best_idx});
      res.hit_start_line <= rd_start[27:12];
      res.hit_start_pos <= rd_start[11:0];
      res.hit_end_line <= rd_end[27:12];
      res.hit_end_pos <= rd_end[11:0];
      res.hit_seq <= rd_seq;
    end
    if (cmd.emit_prior) begin
      res.found <= 1'b1;
      res.prior_kept <= 1'b1;
      if (req.mode == sit_pkg::ModeNext) begin
        res.hit_start_line <= best_key[27:12];
        res.hit_start_pos <= best_key[11:0];
      end else begin
        res.hit_end_line <= best_key[27:12];
        res.hit_end_pos <= best_key[11:0];
      end
    end
  end

  assign sts.full = count >= CW'(sit_pkg::TableDepth);
  assign sts.empty = count == '0;
  assign sts.ptr_at_end = ptr == count;
  assign sts.ge = rd_start >= pt;
  assign sts.ptr_gt_at = ptr > at;
  assign sts.lk_hit = !lt_start && ge_end;
  assign sts.lk_stop = lk_done;
  assign sts.sc_have = have;
  assign sts.sc_prior = is_prior;

  // Every request ends in exactly one emit command; a not-found answer is
  // the all-zero result.
  assign result_valid = res_v;
  assign result = res;

endmodule
`default_nettype wire

// ===== hdl/sorted_interval_table.sv =====
`default_nettype none
// Channel   Signals                      Handshake
// request   start, busy, req             taken when start is high and busy is low
// result    done, res                    done strobes one cycle per request
//
// Each request produces exactly one result strobe; busy drops in the
// next cycle. An insert walks the table for its slot, then shifts
// entries up one at a time, each read and then written back, through the
// single-port entry memory; the closest searches read every entry once.
// Reset clears the entry count and the lookup probe cache; the entry
// memory itself is not cleared. The receiver cannot stall results.
module sorted_interval_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire sit_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output sit_pkg::res_t      res
);

  sit_pkg::cmd_t cmd;
  sit_pkg::sts_t sts;
  sit_pkg::res_t dp_res;
  logic dp_v;

  sit_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(req.mode),
    .point_invalid(req.point_invalid), .sts(sts), .busy(busy), .cmd(cmd)
  );

  sit_dp u_dp (
    .clk(clk), .rst(rst), .req_in(req), .cmd(cmd), .sts(sts),
    .result_valid(dp_v), .result(dp_res)
  );

  // The datapath holds the result register at zero outside the strobe
  // cycle, and every request, not-found lookups included, ends in one emit.
  assign done = dp_v;
  assign res = dp_res;

endmodule
`default_nettype wire

// ===== sim/sorted_interval_table_tb.sv =====
`default_nettype none
module sorted_interval_table_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  sit_pkg::req_t req = '0;
  logic busy;
  logic done;
  sit_pkg::res_t res;

  sorted_interval_table dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .res(res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table. Points are kept as 28-bit keys, line over pos.
  logic [27:0] tbl_start [sit_pkg::TableDepth];
  logic [27:0] tbl_end [sit_pkg::TableDepth];
  logic [15:0] tbl_seq [sit_pkg::TableDepth];
  int unsigned tbl_count;
  int unsigned probe_idx;

  // Results predicted for accepted requests, oldest first.
  sit_pkg::res_t expected_results[$];
  int errors = 0;
  longint cycles = 0;

  // Fill a result from one stored entry.
  function automatic sit_pkg::res_t entry_result(int unsigned idx);
    sit_pkg::res_t r;
    r = '0;
    r.found = 1'b1;
    r.index = idx[7:0];
    {r.hit_start_line, r.hit_start_pos} = tbl_start[idx];
    {r.hit_end_line, r.hit_end_pos} = tbl_end[idx];
    r.hit_seq = tbl_seq[idx];
    return r;
  endfunction

  // Work out the result of one request and update the shadow table.
  function automatic sit_pkg::res_t predict_table(sit_pkg::req_t q);
    sit_pkg::res_t r;
    logic [27:0] pt;
    logic [27:0] best_key;
    int unsigned at, lo, hi, m, best_idx;
    bit have, is_prior;
    r = '0;
    pt = {q.line, q.pos};
    case (q.mode)
      sit_pkg::ModeInsert: begin
        if (tbl_count >= sit_pkg::TableDepth) begin
          r.full_res = 1'b1;
        end else begin
          at = tbl_count;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] >= pt) begin
              at = i;
              break;
            end
          end
          for (int i = tbl_count; i > at; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_end[i] = tbl_end[i-1];
            tbl_seq[i] = tbl_seq[i-1];
          end
          tbl_start[at] = pt;
          tbl_end[at] = {q.stop_line, q.stop_pos};
          tbl_seq[at] = q.seq;
          tbl_count++;
          r = entry_result(at);
        end
      end
      sit_pkg::ModeLookup: begin
        // Binary search whose first probe is the remembered cache index.
        if (!q.point_invalid && tbl_count != 0) begin
          if (probe_idx >= tbl_count) probe_idx = 0;
          lo = 0;
          hi = tbl_count - 1;
          while (int'(lo) <= int'(hi)) begin
            m = probe_idx;
            if (pt < tbl_start[m]) begin
              if (m == 0) return r;
              hi = m - 1;
            end else if (tbl_end[m] <= pt) begin
              lo = m + 1;
            end else begin
              return entry_result(m);
            end
            // The probe moves to the midpoint even when the range empties.
            probe_idx = (lo + hi) / 2;
          end
        end
      end
      default: begin
        have = q.prior_valid;
        is_prior = have;
        best_key = {q.prior_line, q.prior_pos};
        best_idx = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_seq[i][15]) continue;
          if (q.mode == sit_pkg::ModeNext) begin
            if (tbl_start[i] > pt && (!have || best_key > tbl_start[i])) begin
              have = 1; is_prior = 0; best_key = tbl_start[i]; best_idx = i;
            end
          end else begin
            if (tbl_end[i] <= pt && (!have || best_key < tbl_end[i])) begin
              have = 1; is_prior = 0; best_key = tbl_end[i]; best_idx = i;
            end
          end
        end
        if (have) begin
          if (!is_prior) begin
            r = entry_result(best_idx);
          end else begin
            r.found = 1'b1;
            r.prior_kept = 1'b1;
            if (q.mode == sit_pkg::ModeNext) {r.hit_start_line, r.hit_start_pos} = best_key;
            else {r.hit_end_line, r.hit_end_pos} = best_key;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Random points come mostly from a narrow window so that entries overlap
  // and compare equal often, and now and then from the full range.
  function automatic logic [27:0] rand_point();
    if ($urandom_range(0, 3) == 0) return {16'($urandom), 12'($urandom)};
    return {16'($urandom_range(0, 7)), 12'($urandom_range(0, 15))};
  endfunction

  // Send one request after a random gap and record its prediction. The
  // start line stays high between requests sent back to back.
  task automatic send_request(sit_pkg::req_t q);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.insert(expected_results.size(), predict_table(q));
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic sit_pkg::req_t mk_insert(logic [27:0] s, logic [27:0] e,
                                              logic [15:0] sq);
    sit_pkg::req_t q;
    q = '0;
    q.mode = sit_pkg::ModeInsert;
    {q.line, q.pos} = s;
    {q.stop_line, q.stop_pos} = e;
    q.seq = sq;
    return q;
  endfunction

  function automatic sit_pkg::req_t rand_request(logic [1:0] md);
    sit_pkg::req_t q;
    logic [27:0] s;
    q = '0;
    q.mode = md;
    s = rand_point();
    {q.line, q.pos} = s;
    {q.stop_line, q.stop_pos} = ($urandom_range(0, 7) == 0) ? rand_point()
                                  : s + 28'($urandom_range(0, 40));
    q.seq = 16'($urandom);
    q.point_invalid = ($urandom_range(0, 7) == 0);
    q.prior_valid = 1'($urandom_range(0, 1));
    {q.prior_line, q.prior_pos} = rand_point();
    return q;
  endfunction

  // Queries on an empty table, then inserts at the field extremes and
  // queries that hit each special case.
  task automatic test_directed();
    sit_pkg::req_t q;
    q = rand_request(sit_pkg::ModeLookup);
    q.point_invalid = 0;
    send_request(q);
    send_request(rand_request(sit_pkg::ModeNext));
    q = rand_request(sit_pkg::ModePrev);
    q.prior_valid = 1;
    send_request(q);
    send_request(mk_insert(28'h0010_005, 28'h0010_00a, 16'sd5));
    send_request(mk_insert(28'h0000_000, 28'h0000_000, 16'h8000));
    send_request(mk_insert(28'hffff_fff, 28'hffff_fff, 16'h7fff));
    send_request(mk_insert(28'h0010_005, 28'h0020_000, 16'hffff));
    send_request(mk_insert(28'h0020_000, 28'h0030_000, 16'sd1));
    q = '0; q.mode = sit_pkg::ModeLookup; {q.line, q.pos} = 28'h0010_007;
    send_request(q);
    q.point_invalid = 1;
    send_request(q);
    q.point_invalid = 0; {q.line, q.pos} = 28'h0000_000;
    send_request(q);
    {q.line, q.pos} = 28'h0008_000;
    send_request(q);
    q = '0; q.mode = sit_pkg::ModeNext; {q.line, q.pos} = 28'h0000_000;
    send_request(q);
    q.prior_valid = 1; {q.prior_line, q.prior_pos} = 28'h0010_005;
    send_request(q);
    {q.prior_line, q.prior_pos} = 28'h0000_001;
    send_request(q);
    q = '0; q.mode = sit_pkg::ModePrev; {q.line, q.pos} = 28'hffff_fff;
    send_request(q);
    q.prior_valid = 1; {q.prior_line, q.prior_pos} = 28'h0030_000;
    send_request(q);
    {q.prior_line, q.prior_pos} = 28'hffff_fff;
    send_request(q);
  endtask

  // Fill the table to the top, including the full drop, and query it there.
  task automatic test_full_table();
    while (tbl_count < sit_pkg::TableDepth) send_request(rand_request(sit_pkg::ModeInsert));
    send_request(rand_request(sit_pkg::ModeInsert));
    send_request(rand_request(sit_pkg::ModeInsert));
    for (int i = 0; i < 12; i++) send_request(rand_request(2'($urandom_range(1, 3))));
  endtask

  // Mostly queries on the populated table, with a few more full drops.
  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++) begin
      send_request(rand_request(2'($urandom)));
      if (i == n / 2) drain_results();
    end
  endtask

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, res);
        errors++;
      end else begin
        sit_pkg::res_t e;
        e = expected_results.pop_front();
        if (res !== e) begin
          $display("%0t result mismatch: expected %p actual %p", $time, e, res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    tbl_count = 0;
    probe_idx = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    // The table fills only once, so the random part starts small and
    // checks the partly filled table before the full one.
    for (int i = 0; i < 200; i++) send_request(rand_request(2'($urandom)));
    drain_results();
    test_full_table();
    test_random_mix(520);
    drain_results();
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
